### src/pll_pkg.sv
// Shared types, codes and constants of the pooled linked-list engine.
package pll_pkg;

  // Pool geometry: node indices are IDX_W bits, pool addresses ADDR_W bits.
  localparam int POOL_DEPTH = 256;
  localparam int IDX_W      = 9;
  localparam int ADDR_W     = 8;
  localparam logic [IDX_W-1:0] END_NODE = IDX_W'(POOL_DEPTH);

  // Operation codes carried in the func field.
  localparam logic [2:0] FUNC_PUSH   = 3'd0;
  localparam logic [2:0] FUNC_POP    = 3'd1;
  localparam logic [2:0] FUNC_INSERT = 3'd2;
  localparam logic [2:0] FUNC_ERASE  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BADNODE   = 2'd3;

  // Microprogram addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LINK     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_UNLINK   = 3'd4;

  typedef struct packed {
    logic [2:0]       func;
    logic [IDX_W-1:0] node_index;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_node;
    logic [IDX_W-1:0] head_node;
    logic [IDX_W-1:0] list_count;
    logic [IDX_W-1:0] peak_count;
    logic [1:0]       status;
  } out_word_t;

  // Datapath micro-operations selected by the control word.
  typedef enum logic [2:0] {
    UOP_DISPATCH,
    UOP_LINK_A,
    UOP_LINK_B,
    UOP_UNLINK_A,
    UOP_UNLINK_B,
    UOP_EMIT
  } uop_t;

  // Sequencing of the step counter.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_MAP,
    SEQ_JUMP,
    SEQ_RETURN
  } seq_t;

  // Where the dispatch step sends an item.
  typedef enum logic [1:0] {
    ROUTE_EMIT,
    ROUTE_LINK,
    ROUTE_UNLINK
  } route_t;

  typedef struct packed {
    uop_t              uop;
    seq_t              seq;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Sequencer to datapath: the current micro-operation and whether it executes.
  typedef struct packed {
    uop_t uop;
    logic fire;
  } seq_ctl_t;

  // Datapath to sequencer: dispatch outcome and output register state.
  typedef struct packed {
    route_t route;
    logic   out_free;
  } dp_status_t;

endpackage

### src/pll_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
module pll_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pll_pkg::dp_status_t dp_status,
  output pll_pkg::seq_ctl_t seq_ctl,
  output logic              in_stall
);
  import pll_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_word_t        cw;
  logic [STEP_W-1:0] map_target;

  // Control store: one word per step.
  always_comb begin
    case (step)
      3'd0:    cw = '{uop: UOP_DISPATCH, seq: SEQ_MAP,    target: STEP_DISPATCH};
      3'd1:    cw = '{uop: UOP_LINK_A,   seq: SEQ_NEXT,   target: STEP_DISPATCH};
      3'd2:    cw = '{uop: UOP_LINK_B,   seq: SEQ_NEXT,   target: STEP_DISPATCH};
      3'd3:    cw = '{uop: UOP_EMIT,     seq: SEQ_RETURN, target: STEP_DISPATCH};
      3'd4:    cw = '{uop: UOP_UNLINK_A, seq: SEQ_NEXT,   target: STEP_DISPATCH};
      3'd5:    cw = '{uop: UOP_UNLINK_B, seq: SEQ_JUMP,   target: STEP_EMIT};
      default: cw = '{uop: UOP_EMIT,     seq: SEQ_RETURN, target: STEP_DISPATCH};
    endcase
  end

  // Dispatch map from the datapath's routing decision.
  always_comb begin
    case (dp_status.route)
      ROUTE_LINK:   map_target = STEP_LINK;
      ROUTE_UNLINK: map_target = STEP_UNLINK;
      default:      map_target = STEP_EMIT;
    endcase
  end

  // Next step.
  always_comb begin
    case (cw.seq)
      SEQ_NEXT:   step_next = step + 3'd1;
      SEQ_MAP:    step_next = in_valid ? map_target : step;
      SEQ_JUMP:   step_next = cw.target;
      SEQ_RETURN: step_next = dp_status.out_free ? cw.target : step;
      default:    step_next = STEP_DISPATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_DISPATCH;
    end else begin
      step <= step_next;
    end
  end

  // Control outputs: a step waiting on a handshake does not execute.
  always_comb begin
    seq_ctl.uop = cw.uop;
    case (cw.uop)
      UOP_DISPATCH: seq_ctl.fire = in_valid;
      UOP_EMIT:     seq_ctl.fire = dp_status.out_free;
      default:      seq_ctl.fire = 1'b1;
    endcase
  end

  assign in_stall = (step != STEP_DISPATCH);

endmodule

### src/pll_datapath.sv
// Datapath: link memories, membership bits, list registers and result register.
module pll_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [8:0]         cfg_wdata,
  input  pll_pkg::in_word_t  in_word,
  input  pll_pkg::seq_ctl_t  seq_ctl,
  output pll_pkg::dp_status_t dp_status,
  input  logic               out_stall,
  output logic               out_valid,
  output pll_pkg::out_word_t out_word
);
  import pll_pkg::*;

  // List and pool registers.
  logic [IDX_W-1:0] nc;
  logic [IDX_W-1:0] first;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] free_head;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] peak;

  // Per-item working registers.
  logic [IDX_W-1:0] node;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pv;
  logic [IDX_W-1:0] res;
  logic [1:0]       st;
  logic             is_pop;

  // Link memories and per-entry flags.
  logic [IDX_W-1:0]      next_mem [POOL_DEPTH];
  logic [IDX_W-1:0]      prev_mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] nl_valid;
  logic [POOL_DEPTH-1:0] in_list;

  // Registered read data.
  logic [IDX_W-1:0]  nl_q;
  logic              nl_vq;
  logic [ADDR_W-1:0] nl_aq;
  logic [IDX_W-1:0]  pl_q;

  logic              in_accept;
  logic              out_load;
  logic [IDX_W-1:0]  cfg_sat;
  logic [IDX_W-1:0]  idx;
  logic              member;
  logic              clear_go;
  route_t            d_route;
  logic [1:0]        d_st;
  logic [IDX_W-1:0]  d_node;
  logic [IDX_W-1:0]  d_pos;
  logic              d_pop;
  logic [ADDR_W-1:0] nl_raddr;
  logic [ADDR_W-1:0] pl_raddr;
  logic [IDX_W-1:0]  nl_succ;
  logic [IDX_W-1:0]  nl_dflt;
  logic [IDX_W-1:0]  nl_eff;
  logic [IDX_W-1:0]  pv_link;
  logic              nl_we;
  logic [ADDR_W-1:0] nl_waddr;
  logic [IDX_W-1:0]  nl_wdata;
  logic              pl_we;
  logic [ADDR_W-1:0] pl_waddr;
  logic [IDX_W-1:0]  pl_wdata;
  logic [IDX_W-1:0]  count_inc;

  assign in_accept = seq_ctl.fire && (seq_ctl.uop == UOP_DISPATCH);
  assign out_load  = seq_ctl.fire && (seq_ctl.uop == UOP_EMIT);
  assign dp_status.out_free = !out_valid || !out_stall;
  assign dp_status.route    = d_route;

  // A pool size beyond the pool saturates.
  assign cfg_sat = (cfg_wdata > END_NODE) ? END_NODE : cfg_wdata;

  // Membership of the target node.
  assign idx    = in_word.node_index;
  assign member = (idx < END_NODE) && in_list[idx[ADDR_W-1:0]];

  // Dispatch: checks on the incoming word and the route it takes.
  always_comb begin
    d_route  = ROUTE_EMIT;
    d_st     = ST_OK;
    d_node   = first;
    d_pos    = END_NODE;
    d_pop    = 1'b0;
    clear_go = 1'b0;
    case (in_word.func)
      FUNC_PUSH: begin
        if (free_head == END_NODE) begin
          d_st = ST_EXHAUSTED;
        end else begin
          d_route = ROUTE_LINK;
          d_node  = free_head;
        end
      end
      FUNC_POP: begin
        if (first == END_NODE) begin
          d_st = ST_EMPTY;
        end else begin
          d_route = ROUTE_UNLINK;
          d_pop   = 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (idx != END_NODE && !member) begin
          d_st = ST_BADNODE;
        end else if (free_head == END_NODE) begin
          d_st = ST_EXHAUSTED;
        end else begin
          d_route = ROUTE_LINK;
          d_node  = free_head;
          d_pos   = idx;
        end
      end
      FUNC_ERASE: begin
        if (!member) begin
          d_st = ST_BADNODE;
        end else begin
          d_route = ROUTE_UNLINK;
          d_node  = idx;
        end
      end
      FUNC_CLEAR: begin
        clear_go = (first != END_NODE);
      end
      default: begin
      end
    endcase
  end

  // Read addresses issued by the dispatch step.
  assign nl_raddr = d_node[ADDR_W-1:0];
  assign pl_raddr = (d_route == ROUTE_LINK) ? d_pos[ADDR_W-1:0] : d_node[ADDR_W-1:0];

  // An unwritten successor entry still holds the threaded free list.
  assign nl_succ = {1'b0, nl_aq} + 9'd1;
  assign nl_dflt = (nl_succ == nc) ? END_NODE : nl_succ;
  assign nl_eff  = nl_vq ? nl_q : nl_dflt;

  // Predecessor of the new node: the tail when linking at the back, else the target's predecessor.
  assign pv_link   = (pos == END_NODE) ? last : pl_q;
  assign count_inc = count + 9'd1;

  // Write port of the successor memory.
  always_comb begin
    nl_we    = 1'b0;
    nl_waddr = node[ADDR_W-1:0];
    nl_wdata = free_head;
    case (seq_ctl.uop)
      UOP_DISPATCH: begin
        nl_we    = in_accept && clear_go;
        nl_waddr = last[ADDR_W-1:0];
        nl_wdata = free_head;
      end
      UOP_LINK_A: begin
        nl_we    = 1'b1;
        nl_waddr = node[ADDR_W-1:0];
        nl_wdata = pos;
      end
      UOP_LINK_B: begin
        nl_we    = (pv != END_NODE);
        nl_waddr = pv[ADDR_W-1:0];
        nl_wdata = node;
      end
      UOP_UNLINK_A: begin
        nl_we    = (pl_q != END_NODE);
        nl_waddr = pl_q[ADDR_W-1:0];
        nl_wdata = nl_eff;
      end
      UOP_UNLINK_B: begin
        nl_we    = 1'b1;
        nl_waddr = node[ADDR_W-1:0];
        nl_wdata = free_head;
      end
      default: begin
      end
    endcase
  end

  // Write port of the predecessor memory.
  always_comb begin
    pl_we    = 1'b0;
    pl_waddr = node[ADDR_W-1:0];
    pl_wdata = pv_link;
    case (seq_ctl.uop)
      UOP_LINK_A: begin
        pl_we    = 1'b1;
        pl_waddr = node[ADDR_W-1:0];
        pl_wdata = pv_link;
      end
      UOP_LINK_B: begin
        pl_we    = (pos != END_NODE);
        pl_waddr = pos[ADDR_W-1:0];
        pl_wdata = node;
      end
      UOP_UNLINK_A: begin
        pl_we    = (nl_eff != END_NODE);
        pl_waddr = nl_eff[ADDR_W-1:0];
        pl_wdata = pl_q;
      end
      default: begin
      end
    endcase
  end

  // Link memories with registered reads.
  always_ff @(posedge clk) begin
    if (nl_we) begin
      next_mem[nl_waddr] <= nl_wdata;
    end
    if (pl_we) begin
      prev_mem[pl_waddr] <= pl_wdata;
    end
    if (in_accept) begin
      nl_q  <= next_mem[nl_raddr];
      nl_vq <= nl_valid[nl_raddr];
      nl_aq <= nl_raddr;
      pl_q  <= prev_mem[pl_raddr];
    end
  end

  // Written flags of the successor memory.
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      nl_valid <= '0;
    end else if (nl_we) begin
      nl_valid[nl_waddr] <= 1'b1;
    end
  end

  // Membership flags.
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      in_list <= '0;
    end else if (in_accept && clear_go) begin
      in_list <= '0;
    end else if (seq_ctl.uop == UOP_LINK_B) begin
      in_list[node[ADDR_W-1:0]] <= 1'b1;
    end else if (seq_ctl.uop == UOP_UNLINK_B) begin
      in_list[node[ADDR_W-1:0]] <= 1'b0;
    end
  end

  // List, pool and output control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      nc        <= END_NODE;
      first     <= END_NODE;
      last      <= END_NODE;
      free_head <= '0;
      count     <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        nc        <= cfg_sat;
        first     <= END_NODE;
        last      <= END_NODE;
        free_head <= (cfg_sat != '0) ? '0 : END_NODE;
        count     <= '0;
      end
      if (seq_ctl.fire) begin
        case (seq_ctl.uop)
          UOP_DISPATCH: begin
            if (clear_go) begin
              free_head <= first;
              first     <= END_NODE;
              last      <= END_NODE;
              count     <= '0;
            end
          end
          UOP_LINK_A: begin
            free_head <= nl_eff;
          end
          UOP_LINK_B: begin
            if (pv == END_NODE) begin
              first <= node;
            end
            if (pos == END_NODE) begin
              last <= node;
            end
            count <= count_inc;
            if (count_inc > peak) begin
              peak <= count_inc;
            end
          end
          UOP_UNLINK_A: begin
            if (pl_q == END_NODE) begin
              first <= nl_eff;
            end
            if (nl_eff == END_NODE) begin
              last <= pl_q;
            end
          end
          UOP_UNLINK_B: begin
            free_head <= node;
            count     <= count - 9'd1;
          end
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the result word.
  always_ff @(posedge clk) begin
    if (seq_ctl.fire) begin
      case (seq_ctl.uop)
        UOP_DISPATCH: begin
          node   <= d_node;
          pos    <= d_pos;
          st     <= d_st;
          res    <= END_NODE;
          is_pop <= d_pop;
        end
        UOP_LINK_A: begin
          pv <= pv_link;
        end
        UOP_LINK_B: begin
          res <= node;
        end
        UOP_UNLINK_A: begin
          res <= is_pop ? node : nl_eff;
        end
        UOP_EMIT: begin
          out_word.result_node <= res;
          out_word.head_node   <= first;
          out_word.list_count  <= count;
          out_word.peak_count  <= peak;
          out_word.status      <= st;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/pooled_linked_list_engine.sv
// Top level of the pooled linked-list engine.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall   | func, node_index
//   out     | output    | out_valid/out_stall | result_node, head_node,
//           |           |                    | list_count, peak_count, status
//   cfg     | input     | cfg_wen            | node_count (cfg_wdata)
//
// Push and insert run dispatch, two link steps and emit; pop and erase run dispatch,
// two unlink steps and emit; clear, failed and unused operations run dispatch and emit.
// The step sequence is set by the single write port of each link memory and its
// registered read, which the microprogram steps through one access at a time.
// Reset is synchronous; it sets the pool to 256 nodes with an empty list.
// A stalled result holds the emit step; a new word is taken only at dispatch.
module pooled_linked_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  pll_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pll_pkg::out_word_t out_word
);
  import pll_pkg::*;

  seq_ctl_t   seq_ctl;
  dp_status_t dp_status;

  // Microcode sequencer.
  pll_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .dp_status (dp_status),
    .seq_ctl   (seq_ctl),
    .in_stall  (in_stall)
  );

  // Datapath.
  pll_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .seq_ctl   (seq_ctl),
    .dp_status (dp_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  // An accepted word keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after an accepted word");

  // A failed operation never reports a node.
  a_fail_no_node: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status != ST_OK) |-> (out_word.result_node == END_NODE))
    else $error("failed operation reports a node");

  // The peak never falls below the current count.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.list_count <= out_word.peak_count))
    else $error("list count above peak count");

  // An empty head means an empty list and the other way round.
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_word.head_node == END_NODE) == (out_word.list_count == 9'd0)))
    else $error("head node and list count disagree");
`endif

endmodule

### verif/pooled_linked_list_engine_tb.sv
// Self-checking testbench for the pooled linked-list engine, with a list predictor.
`timescale 1ns / 1ps

module pooled_linked_list_engine_tb;
  import pll_pkg::*;

  // Operation codes the block ignores.
  localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 50;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table; a config row carries the pool size in node_index.
  typedef struct packed {
    row_kind_t kind;
    in_word_t  word;
    logic      typed;
    out_word_t expected;
  } dir_row_t;

  localparam out_word_t NO_CHECK = '0;

  localparam dir_row_t DIRECTED [0:26] = '{
    '{ROW_ITEM, '{FUNC_POP,     9'd0},   1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_EMPTY}},
    '{ROW_ITEM, '{FUNC_ERASE,   END_NODE}, 1'b1,
      '{END_NODE, END_NODE, 9'd0, 9'd0, ST_BADNODE}},
    '{ROW_ITEM, '{FUNC_ERASE,   9'd0},   1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_BADNODE}},
    '{ROW_ITEM, '{FUNC_INSERT,  9'd5},   1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_BADNODE}},
    '{ROW_ITEM, '{FUNC_INSERT,  9'd511}, 1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_BADNODE}},
    '{ROW_ITEM, '{FUNC_CLEAR,   9'd0},   1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_OK}},
    '{ROW_ITEM, '{FUNC_SPARE_5, 9'd0},   1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_OK}},
    '{ROW_ITEM, '{FUNC_SPARE_7, 9'd511}, 1'b1, '{END_NODE, END_NODE, 9'd0, 9'd0, ST_OK}},
    '{ROW_ITEM, '{FUNC_PUSH,    9'd0},   1'b1, '{9'd0, 9'd0, 9'd1, 9'd1, ST_OK}},
    '{ROW_ITEM, '{FUNC_PUSH,    9'd511}, 1'b1, '{9'd1, 9'd0, 9'd2, 9'd2, ST_OK}},
    '{ROW_ITEM, '{FUNC_INSERT,  END_NODE}, 1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_INSERT,  9'd0},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_ERASE,   9'd1},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_ERASE,   9'd2},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_POP,     9'd0},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_CLEAR,   9'd0},   1'b0, NO_CHECK},
    '{ROW_CFG,  '{FUNC_PUSH,    9'd0},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_PUSH,    9'd0},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_INSERT,  END_NODE}, 1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_INSERT,  9'd3},   1'b0, NO_CHECK},
    '{ROW_CFG,  '{FUNC_PUSH,    9'd1},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_PUSH,    9'd0},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_PUSH,    9'd0},   1'b0, NO_CHECK},
    '{ROW_CFG,  '{FUNC_PUSH,    9'd511}, 1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_PUSH,    9'd0},   1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_SPARE_6, 9'd256}, 1'b0, NO_CHECK},
    '{ROW_ITEM, '{FUNC_ERASE,   9'd0},   1'b0, NO_CHECK}
  };

  logic      clk;
  logic      rst       = 1'b1;
  logic      cfg_wen   = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  pooled_linked_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted list state, kept in step with every accepted word.
  logic [8:0] lnk_next [256];
  logic [8:0] lnk_prev [256];
  bit         on_list  [256];
  logic [8:0] head, tail, free_top, list_len, peak_len, pool_size;

  out_word_t  pending_results [$];
  int         send_gap_pct = 0;
  int         recv_gap_pct = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  logic       row_typed = 1'b0;
  out_word_t  row_expected = '0;
  out_word_t  want;
  logic       moved;

  // Thread the free list over the pool in use and empty the list.
  function automatic void pool_rethread();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      lnk_next[8'(i)] = 9'(i + 1);
      on_list[8'(i)]  = 1'b0;
    end
    if (pool_size != 0) lnk_next[8'(pool_size - 9'd1)] = END_NODE;
    free_top = (pool_size != 0) ? 9'd0 : END_NODE;
    head     = END_NODE;
    tail     = END_NODE;
    list_len = '0;
  endfunction

  function automatic bit is_listed(logic [8:0] idx);
    return idx < POOL_DEPTH && on_list[idx[7:0]];
  endfunction

  // Take the top free node and link it in front of pos; the end sentinel means the back.
  function automatic logic [8:0] link_in(logic [8:0] pos);
    logic [8:0] n, pv;
    n  = free_top;
    pv = (pos == END_NODE) ? tail : lnk_prev[pos[7:0]];
    free_top = lnk_next[n[7:0]];
    lnk_prev[n[7:0]] = pv;
    lnk_next[n[7:0]] = pos;
    if (pv == END_NODE) head = n; else lnk_next[pv[7:0]] = n;
    if (pos == END_NODE) tail = n; else lnk_prev[pos[7:0]] = n;
    on_list[n[7:0]] = 1'b1;
    list_len++;
    if (peak_len < list_len) peak_len = list_len;
    return n;
  endfunction

  // Unlink a listed node, return it to the free list and give its successor.
  function automatic logic [8:0] unlink(logic [8:0] n);
    logic [8:0] nx, pv;
    nx = lnk_next[n[7:0]];
    pv = lnk_prev[n[7:0]];
    if (pv == END_NODE) head = nx; else lnk_next[pv[7:0]] = nx;
    if (nx == END_NODE) tail = pv; else lnk_prev[nx[7:0]] = pv;
    lnk_next[n[7:0]] = free_top;
    free_top = n;
    on_list[n[7:0]] = 1'b0;
    list_len--;
    return nx;
  endfunction

  // Apply one word to the predicted list and give the result word it causes.
  function automatic out_word_t step_list(in_word_t w);
    logic [8:0] res;
    logic [1:0] st;
    res = END_NODE;
    st  = ST_OK;
    case (w.func)
      FUNC_PUSH: begin
        if (free_top == END_NODE) st = ST_EXHAUSTED;
        else res = link_in(END_NODE);
      end
      FUNC_POP: begin
        if (head == END_NODE) st = ST_EMPTY;
        else begin
          res = head;
          void'(unlink(head));
        end
      end
      FUNC_INSERT: begin
        // The target is checked before the pool.
        if (w.node_index != END_NODE && !is_listed(w.node_index)) st = ST_BADNODE;
        else if (free_top == END_NODE) st = ST_EXHAUSTED;
        else res = link_in(w.node_index);
      end
      FUNC_ERASE: begin
        if (!is_listed(w.node_index)) st = ST_BADNODE;
        else res = unlink(w.node_index);
      end
      FUNC_CLEAR: begin
        if (head != END_NODE) begin
          lnk_next[tail[7:0]] = free_top;
          free_top = head;
          head     = END_NODE;
          tail     = END_NODE;
          list_len = '0;
          for (int i = 0; i < POOL_DEPTH; i++) on_list[8'(i)] = 1'b0;
        end
      end
      default: ;
    endcase
    return '{res, head, list_len, peak_len, st};
  endfunction

  // A node on the list, chosen at random, or any index when the list is empty.
  function automatic logic [8:0] pick_listed();
    logic [8:0] n;
    int k;
    if (list_len == 0) return 9'($urandom);
    k = $urandom_range(list_len - 1);
    n = head;
    repeat (k) n = lnk_next[n[7:0]];
    return n;
  endfunction

  // Draw a random word, mostly well formed, biased towards growth by add_pct.
  function automatic in_word_t draw_word(int add_pct, int clear_pct);
    in_word_t w;
    int r;
    int s;
    w.node_index = 9'($urandom);
    r = $urandom_range(99);
    if (r < 3) begin
      w.func = 3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7));
    end else if (r < 3 + clear_pct) begin
      w.func = FUNC_CLEAR;
    end else if ($urandom_range(99) < add_pct) begin
      if ($urandom_range(1) == 0) begin
        w.func = FUNC_PUSH;
      end else begin
        w.func = FUNC_INSERT;
        s = $urandom_range(99);
        if (s < 70) w.node_index = pick_listed();
        else if (s < 85) w.node_index = END_NODE;
      end
    end else begin
      if ($urandom_range(99) < 35) begin
        w.func = FUNC_POP;
      end else begin
        w.func = FUNC_ERASE;
        if ($urandom_range(99) < 75) w.node_index = pick_listed();
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
  endtask

  // Present one word and hold it until it is taken.
  task automatic send_word(in_word_t w, logic typed, out_word_t exp_word);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_word      <= w;
    row_typed     = typed;
    row_expected  = exp_word;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Write the pool size once every result has drained.
  task automatic write_node_count(logic [8:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_gap_pct);
  end

  // Monitor: check results, track configuration, predict accepted words, watch for hangs.
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("result_node", out_word.result_node, want.result_node);
          check_field("head_node", out_word.head_node, want.head_node);
          check_field("list_count", out_word.list_count, want.list_count);
          check_field("peak_count", out_word.peak_count, want.peak_count);
          check_field("status", out_word.status, want.status);
          if ($isunknown(out_word)) report_mismatch("result word carries unknown bits");
        end
      end
      if (cfg_wen) begin
        moved = 1'b1;
        pool_size = (cfg_wdata > POOL_DEPTH) ? 9'(POOL_DEPTH) : cfg_wdata;
        pool_rethread();
      end
      if (in_valid && in_stall === 1'b0) begin
        moved = 1'b1;
        want = step_list(in_word);
        pending_results.push_back(row_typed ? row_expected : want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int made;
    int seg_len;
    int seg_done;
    int add_pct;
    int clear_pct;
    int phase;
    logic [8:0] size_val;
    in_word_t w;

    // Predicted state after reset.
    pool_size = 9'(POOL_DEPTH);
    peak_len  = '0;
    for (int i = 0; i < POOL_DEPTH; i++) lnk_prev[8'(i)] = '0;
    pool_rethread();

    send_gap_pct = 22;
    recv_gap_pct = 79;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) write_node_count(DIRECTED[i].word.node_index);
      else send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].expected);
    end

    // Random segments, each under a fresh pool size.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase = made * 3 / RANDOM_ITEMS;
      send_gap_pct = (phase == 0) ? 22 : (phase == 1) ? 79 : 0;
      recv_gap_pct = (phase == 0) ? 79 : (phase == 1) ? 22 : 0;
      seg_len   = $urandom_range(30, 80);
      add_pct   = $urandom_range(40, 75);
      clear_pct = 2;
      case ($urandom_range(9))
        0, 1, 2, 3: size_val = 9'($urandom_range(1, 12));
        4: begin
          // Fill the whole pool to reach exhaustion at full size.
          size_val  = 9'(POOL_DEPTH);
          seg_len   = 360;
          add_pct   = 92;
          clear_pct = 0;
        end
        5: begin
          size_val = '0;
          seg_len  = 20;
        end
        6: size_val = 9'($urandom_range(POOL_DEPTH + 1, 511));
        7: size_val = 9'($urandom_range(1, POOL_DEPTH));
        8: size_val = 9'd1;
        default: size_val = 9'd2;
      endcase
      write_node_count(size_val);
      seg_done = 0;
      while (seg_done < seg_len) begin
        w = draw_word(add_pct, clear_pct);
        send_word(w, 1'b0, NO_CHECK);
        if (w.func <= FUNC_CLEAR) begin
          seg_done++;
          made++;
        end
      end
    end

    // Drain, then watch for any stray result word.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
src/pll_pkg.sv
src/pll_sequencer.sv
src/pll_datapath.sv
src/pooled_linked_list_engine.sv
verif/pooled_linked_list_engine_tb.sv
